/* src/fat16_cluster_chain_walker_assert.svh */
// Assertion macros used by the chain walker back end (fcw_back).
// Define ASSERT_OFF to compile them out.
`ifndef FAT16_CLUSTER_CHAIN_WALKER_ASSERT_SVH
`define FAT16_CLUSTER_CHAIN_WALKER_ASSERT_SVH

`ifndef ASSERT_OFF

// Property that must hold on every clock edge out of reset
`define FCW_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Same-cycle implication
`define FCW_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication
`define FCW_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`else

`define FCW_ASSERT(lbl, clk, rstn, prop, msg)
`define FCW_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg)
`define FCW_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg)

`endif

`endif

/* src/fcw_pkg.sv */
package fcw_pkg;

    // Defaults for the top-level parameters
    localparam int TABLE_ENTRIES_DEF = 32768;
    localparam int CLUSTER_BYTES_DEF = 2048;
    localparam int MAX_CLUSTERS_DEF  = 64;

    // Depth of the queue between classifier and walker
    localparam int QUEUE_DEPTH = 2;

    // Volume geometry constants
    localparam logic [15:0] CHAIN_END       = 16'hFFF8;
    localparam int          SECTOR_BYTES    = 512;
    localparam int          DIR_ENTRY_BYTES = 32;
    localparam int          SECTOR_SHIFT    = $clog2(SECTOR_BYTES);
    localparam int          DIR_SHIFT       = $clog2(DIR_ENTRY_BYTES);

    // Function codes on the input channel
    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_READ  = 1'b1;

    // Configuration register indexes
    localparam logic [2:0] REG_PART_OFFSET  = 3'd0;
    localparam logic [2:0] REG_RESERVED     = 3'd1;
    localparam logic [2:0] REG_FAT_COPIES   = 3'd2;
    localparam logic [2:0] REG_SECT_PER_FAT = 3'd3;
    localparam logic [2:0] REG_ROOT_ENTRIES = 3'd4;
    localparam logic [2:0] REG_SECT_PER_CLU = 3'd5;
    localparam logic [2:0] REG_READY        = 3'd6;

    typedef enum logic [1:0] {
        ST_COMPLETE  = 2'd0,
        ST_CHAIN_END = 2'd1,
        ST_NOT_READY = 2'd2,
        ST_BEYOND    = 2'd3
    } status_t;

    // Work kinds handed from the classifier to the walker
    typedef enum logic [1:0] {
        OP_WRITE  = 2'd0,
        OP_SINGLE = 2'd1,
        OP_WALK   = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        S_IDLE = 2'd0,
        S_MUL  = 2'd1,
        S_WAIT = 2'd2,
        S_EMIT = 2'd3
    } back_state_t;

    // Settled volume geometry seen by the front and back parts
    typedef struct packed {
        logic [31:0] base;
        logic [7:0]  spc;
        logic        ready;
    } cfg_t;

    typedef struct packed {
        op_t         op;
        status_t     status;
        logic [15:0] cluster;
        logic [17:0] size;
        logic [14:0] index;
        logic [15:0] value;
    } req_t;

endpackage

/* src/fat16_cluster_chain_walker.sv */
// FAT16 cluster chain walker.
// Input channel (s_*): func 0 writes one allocation table entry, func 1 starts a
// read of a file: start cluster, request size, file size. All transfers but
// out-of-range table writes enter a two-entry queue; s_ready drops only if full.
// Result channel (m_*): one descriptor per cluster of the walk (sector LBA, sector
// count, byte count, buffer offset, running total); the final one carries m_last
// and the status. A read that is not ready or has nothing to walk gives one
// zero descriptor. Table writes give no result.
// Configuration channel (cfg_*): always ready; write only while the block is idle.
// The data area start is derived through a multiply stage, then an add stage.
// A table write is done while the walker is idle. A read walks the chain one
// cluster at a time: a multiply, then one table lookup on the single read port;
// the walker takes the next queued transfer only once the walk has ended.
// Reset returns the configuration registers to their defaults and empties the
// queue and output register; the table is not cleared and holds undefined data
// until written. A stalled receiver holds the output register and the walk
// waits; the queue keeps accepting until full.
module fat16_cluster_chain_walker #(
    parameter int TABLE_ENTRIES = fcw_pkg::TABLE_ENTRIES_DEF,
    parameter int CLUSTER_BYTES = fcw_pkg::CLUSTER_BYTES_DEF,
    parameter int MAX_CLUSTERS  = fcw_pkg::MAX_CLUSTERS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_func,
    input  logic [14:0] s_fat_index,
    input  logic [15:0] s_fat_value,
    input  logic [15:0] s_first_cluster,
    input  logic [17:0] s_request_size,
    input  logic [31:0] s_file_len,

    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_sector_lba,
    output logic [7:0]  m_sector_count,
    output logic [11:0] m_byte_count,
    output logic [17:0] m_buffer_offset,
    output logic [17:0] m_total_bytes,
    output logic [1:0]  m_status,
    output logic        m_last
);

    localparam int AW = $clog2(TABLE_ENTRIES);

    fcw_pkg::cfg_t  cfg;
    fcw_pkg::req_t  push_data;
    fcw_pkg::req_t  q_data;
    logic           q_full;
    logic           q_push;
    logic           q_pop;
    logic           q_valid;

    logic           ram_we;
    logic [AW-1:0]  ram_waddr;
    logic [15:0]    ram_wdata;
    logic           ram_re;
    logic [AW-1:0]  ram_raddr;
    logic [15:0]    ram_rdata;

    fcw_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    fcw_front #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .CLUSTER_BYTES (CLUSTER_BYTES),
        .MAX_CLUSTERS  (MAX_CLUSTERS)
    ) u_front (
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_func          (s_func),
        .s_fat_index     (s_fat_index),
        .s_fat_value     (s_fat_value),
        .s_first_cluster (s_first_cluster),
        .s_request_size  (s_request_size),
        .s_file_len      (s_file_len),
        .cfg             (cfg),
        .q_full          (q_full),
        .q_push          (q_push),
        .q_data          (push_data)
    );

    fcw_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (push_data),
        .full      (q_full),
        .pop       (q_pop),
        .q_valid   (q_valid),
        .q_data    (q_data)
    );

    fcw_ram #(
        .WIDTH (16),
        .DEPTH (TABLE_ENTRIES)
    ) u_table (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    fcw_back #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .CLUSTER_BYTES (CLUSTER_BYTES)
    ) u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .q_valid         (q_valid),
        .q_data          (q_data),
        .q_pop           (q_pop),
        .cfg             (cfg),
        .ram_we          (ram_we),
        .ram_waddr       (ram_waddr),
        .ram_wdata       (ram_wdata),
        .ram_re          (ram_re),
        .ram_raddr       (ram_raddr),
        .ram_rdata       (ram_rdata),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_sector_lba    (m_sector_lba),
        .m_sector_count  (m_sector_count),
        .m_byte_count    (m_byte_count),
        .m_buffer_offset (m_buffer_offset),
        .m_total_bytes   (m_total_bytes),
        .m_status        (m_status),
        .m_last          (m_last)
    );

endmodule

/* src/fcw_ram.sv */
module fcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = fcw_pkg::TABLE_ENTRIES_DEF
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* src/fcw_cfg.sv */
module fcw_cfg (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    output fcw_pkg::cfg_t      cfg
);

    logic [31:0] part_offset_reg, part_offset_next;
    logic [15:0] reserved_reg, reserved_next;
    logic [7:0]  fat_copies_reg, fat_copies_next;
    logic [15:0] spf_reg, spf_next;
    logic [15:0] root_reg, root_next;
    logic [7:0]  spc_reg, spc_next;
    logic        ready_reg, ready_next;

    logic [23:0] prod_reg, prod_next;
    logic [16:0] fixed_reg, fixed_next;
    logic [31:0] base_reg, base_next;

    logic [21:0] root_bytes;
    logic [12:0] root_secs;

    assign cfg_ready = 1'b1;

    // Decode register writes
    always_comb begin
        part_offset_next = part_offset_reg;
        reserved_next    = reserved_reg;
        fat_copies_next  = fat_copies_reg;
        spf_next         = spf_reg;
        root_next        = root_reg;
        spc_next         = spc_reg;
        ready_next       = ready_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                fcw_pkg::REG_PART_OFFSET:  part_offset_next = cfg_data;
                fcw_pkg::REG_RESERVED:     reserved_next    = cfg_data[15:0];
                fcw_pkg::REG_FAT_COPIES:   fat_copies_next  = cfg_data[7:0];
                fcw_pkg::REG_SECT_PER_FAT: spf_next         = cfg_data[15:0];
                fcw_pkg::REG_ROOT_ENTRIES: root_next        = cfg_data[15:0];
                fcw_pkg::REG_SECT_PER_CLU: spc_next         = cfg_data[7:0];
                fcw_pkg::REG_READY:        ready_next       = cfg_data[0];
                default: ;
            endcase
        end
    end

    // Data area start: two stages, multiply first, then the three-way add
    always_comb begin
        root_bytes = (22'(root_reg) << fcw_pkg::DIR_SHIFT) + 22'(fcw_pkg::SECTOR_BYTES - 1);
        root_secs  = 13'(root_bytes >> fcw_pkg::SECTOR_SHIFT);
        prod_next  = 24'(fat_copies_reg) * 24'(spf_reg);
        fixed_next = 17'(reserved_reg) + 17'(root_secs);
        base_next  = part_offset_reg + 32'(prod_reg) + 32'(fixed_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            part_offset_reg <= 32'd2048;
            reserved_reg    <= 16'd1;
            fat_copies_reg  <= 8'd2;
            spf_reg         <= 16'd256;
            root_reg        <= 16'd512;
            spc_reg         <= 8'd4;
            ready_reg       <= 1'b0;
        end else begin
            part_offset_reg <= part_offset_next;
            reserved_reg    <= reserved_next;
            fat_copies_reg  <= fat_copies_next;
            spf_reg         <= spf_next;
            root_reg        <= root_next;
            spc_reg         <= spc_next;
            ready_reg       <= ready_next;
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg  <= prod_next;
        fixed_reg <= fixed_next;
        base_reg  <= base_next;
    end

    assign cfg.base  = base_reg;
    assign cfg.spc   = spc_reg;
    assign cfg.ready = ready_reg;

endmodule

/* src/fcw_front.sv */
module fcw_front #(
    parameter int TABLE_ENTRIES = fcw_pkg::TABLE_ENTRIES_DEF,
    parameter int CLUSTER_BYTES = fcw_pkg::CLUSTER_BYTES_DEF,
    parameter int MAX_CLUSTERS  = fcw_pkg::MAX_CLUSTERS_DEF
) (
    input  logic           s_valid,
    output logic           s_ready,
    input  logic           s_func,
    input  logic [14:0]    s_fat_index,
    input  logic [15:0]    s_fat_value,
    input  logic [15:0]    s_first_cluster,
    input  logic [17:0]    s_request_size,
    input  logic [31:0]    s_file_len,
    input  fcw_pkg::cfg_t  cfg,
    input  logic           q_full,
    output logic           q_push,
    output fcw_pkg::req_t  q_data
);

    localparam logic [31:0] CAP = 32'(MAX_CLUSTERS * CLUSTER_BYTES);

    logic [17:0] size_c;
    logic        in_range;

    // Clamp the request to the file size and to the walk limit
    always_comb begin
        size_c = s_request_size;
        if (32'(size_c) > s_file_len) begin
            size_c = s_file_len[17:0];
        end
        if (32'(size_c) > CAP) begin
            size_c = CAP[17:0];
        end
    end

    assign in_range = 17'(s_fat_index) < 17'(TABLE_ENTRIES);

    // Classify the transfer
    always_comb begin
        q_data.op      = fcw_pkg::OP_WALK;
        q_data.status  = fcw_pkg::ST_COMPLETE;
        q_data.cluster = s_first_cluster;
        q_data.size    = size_c;
        q_data.index   = s_fat_index;
        q_data.value   = s_fat_value;
        priority if (s_func == fcw_pkg::FUNC_WRITE) begin
            q_data.op = fcw_pkg::OP_WRITE;
        end else if (!cfg.ready) begin
            q_data.op     = fcw_pkg::OP_SINGLE;
            q_data.status = fcw_pkg::ST_NOT_READY;
        end else if (size_c == 18'd0) begin
            q_data.op     = fcw_pkg::OP_SINGLE;
            q_data.status = fcw_pkg::ST_COMPLETE;
        end else if (s_first_cluster >= fcw_pkg::CHAIN_END) begin
            q_data.op     = fcw_pkg::OP_SINGLE;
            q_data.status = fcw_pkg::ST_CHAIN_END;
        end else begin
            q_data.op = fcw_pkg::OP_WALK;
        end
    end

    // Drop table writes outside the table; they are accepted all the same
    assign s_ready = !q_full;
    assign q_push  = s_valid && !q_full && !(s_func == fcw_pkg::FUNC_WRITE && !in_range);

endmodule

/* src/fcw_queue.sv */
module fcw_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  fcw_pkg::req_t  push_data,
    output logic           full,
    input  logic           pop,
    output logic           q_valid,
    output fcw_pkg::req_t  q_data
);

    localparam int DEPTH = fcw_pkg::QUEUE_DEPTH;
    localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = $clog2(DEPTH + 1);

    fcw_pkg::req_t entries [DEPTH];

    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          do_push, do_pop;

    assign full    = (count_reg == CW'(DEPTH));
    assign q_valid = (count_reg != '0);
    assign q_data  = entries[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && q_valid;

    // Advance pointers with wrap
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entries[wr_ptr_reg] <= push_data;
        end
    end

endmodule

/* src/fcw_back.sv */
`include "fat16_cluster_chain_walker_assert.svh"

module fcw_back #(
    parameter int TABLE_ENTRIES = fcw_pkg::TABLE_ENTRIES_DEF,
    parameter int CLUSTER_BYTES = fcw_pkg::CLUSTER_BYTES_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             q_valid,
    input  fcw_pkg::req_t                    q_data,
    output logic                             q_pop,
    input  fcw_pkg::cfg_t                    cfg,
    output logic                             ram_we,
    output logic [$clog2(TABLE_ENTRIES)-1:0] ram_waddr,
    output logic [15:0]                      ram_wdata,
    output logic                             ram_re,
    output logic [$clog2(TABLE_ENTRIES)-1:0] ram_raddr,
    input  logic [15:0]                      ram_rdata,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [31:0]                      m_sector_lba,
    output logic [7:0]                       m_sector_count,
    output logic [11:0]                      m_byte_count,
    output logic [17:0]                      m_buffer_offset,
    output logic [17:0]                      m_total_bytes,
    output logic [1:0]                       m_status,
    output logic                             m_last
);

    localparam int AW = $clog2(TABLE_ENTRIES);
    localparam int CW = $clog2(CLUSTER_BYTES + 1);

    fcw_pkg::back_state_t state_reg, state_next;

    logic [15:0]       cluster_reg, cluster_next;
    logic [17:0]       remain_reg, remain_next;
    logic [17:0]       done_reg, done_next;
    logic [CW-1:0]     chunk_reg, chunk_next;
    logic [31:0]       mul_reg, mul_next;
    fcw_pkg::status_t  status_reg, status_next;
    logic              last_reg, last_next;

    logic              m_valid_reg, m_valid_next;
    logic [31:0]       lba_reg, lba_next;
    logic [7:0]        cnt_reg, cnt_next;
    logic [11:0]       bytes_reg, bytes_next;
    logic [17:0]       offs_reg, offs_next;
    logic [17:0]       total_reg, total_next;
    fcw_pkg::status_t  ost_reg, ost_next;
    logic              olast_reg, olast_next;

    logic              out_free;
    logic [CW-1:0]     chunk_c;
    logic [17:0]       rem_after;
    logic              beyond;
    logic              next_end;
    logic              emit;
    logic              emit_single;
    logic              emit_last;
    fcw_pkg::status_t  emit_status;
    logic [16:0]       waddr_wide;
    logic [16:0]       raddr_wide;

    // Per-cluster arithmetic
    assign out_free  = !m_valid_reg || m_ready;
    assign chunk_c   = (remain_reg < 18'(CLUSTER_BYTES)) ? CW'(remain_reg) : CW'(CLUSTER_BYTES);
    assign rem_after = remain_reg - 18'(chunk_c);
    assign beyond    = 17'(cluster_reg) >= 17'(TABLE_ENTRIES);
    assign next_end  = ram_rdata >= fcw_pkg::CHAIN_END;

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            fcw_pkg::S_IDLE: begin
                if (q_valid && q_data.op == fcw_pkg::OP_WALK) begin
                    state_next = fcw_pkg::S_MUL;
                end
            end
            fcw_pkg::S_MUL: begin
                if (rem_after != 18'd0 && !beyond) begin
                    state_next = fcw_pkg::S_WAIT;
                end else begin
                    state_next = fcw_pkg::S_EMIT;
                end
            end
            fcw_pkg::S_WAIT: begin
                if (!out_free) begin
                    state_next = fcw_pkg::S_EMIT;
                end else if (next_end) begin
                    state_next = fcw_pkg::S_IDLE;
                end else begin
                    state_next = fcw_pkg::S_MUL;
                end
            end
            fcw_pkg::S_EMIT: begin
                if (out_free) begin
                    state_next = last_reg ? fcw_pkg::S_IDLE : fcw_pkg::S_MUL;
                end
            end
            default: state_next = fcw_pkg::S_IDLE;
        endcase
    end

    // Control strobes
    always_comb begin
        ram_we      = (state_reg == fcw_pkg::S_IDLE) && q_valid
                      && (q_data.op == fcw_pkg::OP_WRITE);
        emit_single = (state_reg == fcw_pkg::S_IDLE) && q_valid
                      && (q_data.op == fcw_pkg::OP_SINGLE) && out_free;
        q_pop       = (state_reg == fcw_pkg::S_IDLE) && q_valid
                      && ((q_data.op != fcw_pkg::OP_SINGLE) || out_free);
        ram_re      = (state_reg == fcw_pkg::S_MUL) && (rem_after != 18'd0) && !beyond;
        emit        = ((state_reg == fcw_pkg::S_WAIT) || (state_reg == fcw_pkg::S_EMIT))
                      && out_free;
        if (state_reg == fcw_pkg::S_WAIT) begin
            emit_last   = next_end;
            emit_status = next_end ? fcw_pkg::ST_CHAIN_END : fcw_pkg::ST_COMPLETE;
        end else begin
            emit_last   = last_reg;
            emit_status = status_reg;
        end
    end

    // Table addresses
    assign waddr_wide = 17'(q_data.index);
    assign raddr_wide = 17'(cluster_reg);
    assign ram_waddr  = waddr_wide[AW-1:0];
    assign ram_wdata  = q_data.value;
    assign ram_raddr  = raddr_wide[AW-1:0];

    // Walk registers
    always_comb begin
        cluster_next = cluster_reg;
        remain_next  = remain_reg;
        done_next    = done_reg;
        chunk_next   = chunk_reg;
        mul_next     = mul_reg;
        status_next  = status_reg;
        last_next    = last_reg;
        unique case (state_reg)
            fcw_pkg::S_IDLE: begin
                if (q_valid && q_data.op == fcw_pkg::OP_WALK) begin
                    cluster_next = q_data.cluster;
                    remain_next  = q_data.size;
                    done_next    = '0;
                end
            end
            fcw_pkg::S_MUL: begin
                mul_next    = (32'(cluster_reg) - 32'd2) * 32'(cfg.spc);
                chunk_next  = chunk_c;
                remain_next = rem_after;
                if (!ram_re) begin
                    last_next   = 1'b1;
                    status_next = (rem_after != 18'd0) ? fcw_pkg::ST_BEYOND
                                                       : fcw_pkg::ST_COMPLETE;
                end
            end
            fcw_pkg::S_WAIT: begin
                cluster_next = ram_rdata;
                last_next    = emit_last;
                status_next  = emit_status;
            end
            default: ;
        endcase
        if (emit) begin
            done_next = done_reg + 18'(chunk_reg);
        end
    end

    // Output register: load a descriptor, drop it once taken
    always_comb begin
        m_valid_next = m_valid_reg;
        lba_next     = lba_reg;
        cnt_next     = cnt_reg;
        bytes_next   = bytes_reg;
        offs_next    = offs_reg;
        total_next   = total_reg;
        ost_next     = ost_reg;
        olast_next   = olast_reg;
        priority if (emit_single) begin
            m_valid_next = 1'b1;
            lba_next     = '0;
            cnt_next     = '0;
            bytes_next   = '0;
            offs_next    = '0;
            total_next   = '0;
            ost_next     = q_data.status;
            olast_next   = 1'b1;
        end else if (emit) begin
            m_valid_next = 1'b1;
            lba_next     = cfg.base + mul_reg;
            cnt_next     = cfg.spc;
            bytes_next   = 12'(chunk_reg);
            offs_next    = done_reg;
            total_next   = done_reg + 18'(chunk_reg);
            ost_next     = emit_status;
            olast_next   = emit_last;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= fcw_pkg::S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cluster_reg <= cluster_next;
        remain_reg  <= remain_next;
        done_reg    <= done_next;
        chunk_reg   <= chunk_next;
        mul_reg     <= mul_next;
        status_reg  <= status_next;
        last_reg    <= last_next;
        lba_reg     <= lba_next;
        cnt_reg     <= cnt_next;
        bytes_reg   <= bytes_next;
        offs_reg    <= offs_next;
        total_reg   <= total_next;
        ost_reg     <= ost_next;
        olast_reg   <= olast_next;
    end

    assign m_valid         = m_valid_reg;
    assign m_sector_lba    = lba_reg;
    assign m_sector_count  = cnt_reg;
    assign m_byte_count    = bytes_reg;
    assign m_buffer_offset = offs_reg;
    assign m_total_bytes   = total_reg;
    assign m_status        = ost_reg;
    assign m_last          = olast_reg;

    // A table lookup is always followed by the cycle that consumes its data
    `FCW_ASSERT_NXT(a_read_then_wait, aclk, aresetn, ram_re, state_reg == fcw_pkg::S_WAIT, "table read not followed by wait state")
    // Table writes and chain lookups never share the port cycle
    `FCW_ASSERT(a_no_rw_clash, aclk, aresetn, !(ram_we && ram_re), "table write and read in one cycle")
    // Lookups stay inside the table
    `FCW_ASSERT_IMP(a_read_in_range, aclk, aresetn, ram_re, 17'(cluster_reg) < 17'(TABLE_ENTRIES), "table read beyond table")
    // The final descriptor of a walk ends the walk
    `FCW_ASSERT_NXT(a_last_ends_walk, aclk, aresetn, emit && emit_last, state_reg == fcw_pkg::S_IDLE, "walk continues after last descriptor")

endmodule
